@@ rtl/core/vertex_normal_accumulator_unit_assert.svh @@
// Assertion macros shared by the vertex normal accumulator RTL.
`ifndef VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define VNACC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define VNACC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vnacc_pkg.sv @@
// Shared types, codes and constants of the vertex normal accumulator.
package vnacc_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int POS_BITS_DEF     = 16;

    localparam int ACC_W        = 48;
    localparam int IDX_W        = 10;
    localparam int FIELD_W      = 16;
    localparam int OUT_W        = 16;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 64;
    localparam int SUB_W        = 64;
    localparam int SHIFT_LIMIT  = 31;
    localparam int Q_FRAC       = 14;
    localparam int NUM_W        = SHIFT_LIMIT + Q_FRAC + 1;
    localparam int DIV_Q_BITS   = 15;
    localparam int SQRT_STEPS   = 32;
    localparam int STEP_W       = 5;
    localparam int CROSS_TERMS  = 6;
    localparam int SQ_TERMS     = 3;
    localparam int MIN_TRI      = 3;
    localparam int ONE_Q14      = 16384;
    localparam int LAST_COMP    = 2;

    localparam logic [1:0] DIMS_2D = 2'd2;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TRI   = 2'd1,
        KIND_READ  = 2'd2,
        KIND_CLEAR = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_FEW       = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_TR_B,
        S_TR_C,
        S_TR_E,
        S_MUL,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_LOAD,
        S_SHIFT,
        S_SQUARE,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_RESP
    } state_t;

endpackage

@@ rtl/core/vnacc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vnacc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/vnacc_alu.sv @@
// Shared arithmetic unit: signed multiplier and wide subtract-compare.
module vnacc_alu (
    input  logic signed [vnacc_pkg::MUL_W-1:0]  mul_a,
    input  logic signed [vnacc_pkg::MUL_W-1:0]  mul_b,
    output logic signed [vnacc_pkg::PROD_W-1:0] product,
    input  logic        [vnacc_pkg::SUB_W-1:0]  sub_a,
    input  logic        [vnacc_pkg::SUB_W-1:0]  sub_b,
    output logic        [vnacc_pkg::SUB_W-1:0]  diff,
    output logic                                ge
);

    logic [vnacc_pkg::SUB_W:0] diff_full;

    assign product   = vnacc_pkg::PROD_W'(mul_a) * vnacc_pkg::PROD_W'(mul_b);
    assign diff_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign diff      = diff_full[vnacc_pkg::SUB_W-1:0];
    assign ge        = !diff_full[vnacc_pkg::SUB_W];

endmodule

@@ rtl/core/vertex_normal_accumulator_unit.sv @@
// Top level: vertex store, accumulators, sequencer and normalizer.
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-----------
//  cfg     | cfg_we, cfg_wdata (vertex_dims)                  | write on we
//  in      | kind, pos_x/y/z, corner_a/b/c, query_index       | valid/ready
//  out     | normal_x/y/z, status                             | valid/ready
//
//  Load, clear and rejected items go straight to the response. A triangle reads
//  three corners, forms six products and updates three accumulators. A read of an
//  untouched vertex or a zero sum also goes straight on; any other read shifts,
//  squares, takes 32 root steps and divides, through the one multiplier/subtractor.
//  Accumulators are zeroed as each slot is loaded, so reset needs no sweep.
//  A stalled result holds in the output register; in_ready drops while busy.
module vertex_normal_accumulator_unit #(
    parameter int MAX_VERTICES = vnacc_pkg::MAX_VERTICES_DEF,
    parameter int POS_BITS     = vnacc_pkg::POS_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [1:0]                           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           kind,
    input  logic signed [vnacc_pkg::FIELD_W-1:0] pos_x,
    input  logic signed [vnacc_pkg::FIELD_W-1:0] pos_y,
    input  logic signed [vnacc_pkg::FIELD_W-1:0] pos_z,
    input  logic [vnacc_pkg::IDX_W-1:0]          corner_a,
    input  logic [vnacc_pkg::IDX_W-1:0]          corner_b,
    input  logic [vnacc_pkg::IDX_W-1:0]          corner_c,
    input  logic [vnacc_pkg::IDX_W-1:0]          query_index,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [vnacc_pkg::OUT_W-1:0]   normal_x,
    output logic signed [vnacc_pkg::OUT_W-1:0]   normal_y,
    output logic signed [vnacc_pkg::OUT_W-1:0]   normal_z,
    output logic [1:0]                           status
);

    localparam int AW      = $clog2(MAX_VERTICES);
    localparam int CW      = $clog2(MAX_VERTICES + 1);
    localparam int CMPW    = (CW > vnacc_pkg::IDX_W) ? CW : vnacc_pkg::IDX_W;
    localparam int VW      = 3 * POS_BITS;
    localparam int ADW     = 1 + 3 * vnacc_pkg::ACC_W;
    localparam int EW      = POS_BITS + 1;
    localparam int CROSS_W = 2 * EW + 1;
    localparam int SUM_W   = ((CROSS_W > vnacc_pkg::ACC_W) ? CROSS_W : vnacc_pkg::ACC_W) + 1;
    localparam int EXT_W   = (POS_BITS > vnacc_pkg::FIELD_W) ? POS_BITS : vnacc_pkg::FIELD_W;
    localparam int ACC_W   = vnacc_pkg::ACC_W;
    localparam int SW      = vnacc_pkg::STEP_W;

    function automatic logic [POS_BITS-1:0] pos_word(input logic [vnacc_pkg::FIELD_W-1:0] v);
        logic [EXT_W-1:0] e;
        e = EXT_W'(v);
        return e[POS_BITS-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   a,
        input logic signed [CROSS_W-1:0] b
    );
        logic signed [SUM_W-1:0] r;
        r = SUM_W'(a) + SUM_W'(b);
        if (&r[SUM_W-1:ACC_W-1] || !(|r[SUM_W-1:ACC_W-1]))
        begin
            return r[ACC_W-1:0];
        end
        else if (r[SUM_W-1])
        begin
            return {1'b1, {(ACC_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(ACC_W-1){1'b1}}};
        end
    endfunction

    vnacc_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]      count_reg;
    logic [1:0]         dims_reg;
    logic [SW-1:0]      step_reg;
    logic [1:0]         comp_reg;
    logic               out_valid_reg;

    vnacc_pkg::kind_t   kind_reg;
    logic [VW-1:0]      vword_reg;
    logic [vnacc_pkg::IDX_W-1:0] corner_reg [3];
    logic [vnacc_pkg::IDX_W-1:0] query_reg;
    logic signed [POS_BITS-1:0]  p0_reg [3];
    logic signed [POS_BITS-1:0]  p1_reg [3];
    logic signed [EW-1:0]        e1_reg [3];
    logic signed [EW-1:0]        e2_reg [3];
    logic signed [vnacc_pkg::PROD_W-1:0] prod_reg;
    logic signed [CROSS_W-1:0]   cross_reg [3];
    logic [ACC_W-1:0]            mag_reg [3];
    logic                        neg_reg [3];
    logic [vnacc_pkg::SUB_W-1:0] sq_reg;
    logic [vnacc_pkg::SUB_W-1:0] root_reg;
    logic [vnacc_pkg::SUB_W-1:0] bit_reg;
    logic [31:0]                 len_reg;
    logic [vnacc_pkg::NUM_W-1:0] num_reg;
    logic [vnacc_pkg::DIV_Q_BITS-1:0] quo_reg;
    logic signed [vnacc_pkg::OUT_W-1:0] res_reg [3];
    vnacc_pkg::status_t          stat_reg;
    logic signed [vnacc_pkg::OUT_W-1:0] nx_reg, ny_reg, nz_reg;
    vnacc_pkg::status_t          status_reg;

    logic              vram_we;
    logic [AW-1:0]     vram_waddr, vram_raddr;
    logic [VW-1:0]     vram_rdata;
    logic              aram_we;
    logic [AW-1:0]     aram_waddr, aram_raddr;
    logic [ADW-1:0]    aram_wdata, aram_rdata;

    logic signed [vnacc_pkg::MUL_W-1:0]  mul_a, mul_b;
    logic signed [vnacc_pkg::PROD_W-1:0] product;
    logic [vnacc_pkg::SUB_W-1:0]         sub_a, sub_b, diff;
    logic                                ge;

    logic              full, few, bad_tri, bad_q;
    logic              touched_rd, zero_sum, any_big;
    logic signed [ACC_W-1:0] acc_rd [3];
    logic signed [POS_BITS-1:0] v_rd [3];
    logic [ACC_W-1:0]  sel_mag;
    logic [vnacc_pkg::DIV_Q_BITS-1:0] quo_next;
    logic [vnacc_pkg::OUT_W-1:0] q16;
    logic              resp_load;

    vnacc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vword_reg),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    vnacc_ram #(.WIDTH(ADW), .DEPTH(MAX_VERTICES)) u_aram (
        .clk   (clk),
        .we    (aram_we),
        .waddr (aram_waddr),
        .wdata (aram_wdata),
        .raddr (aram_raddr),
        .rdata (aram_rdata)
    );

    vnacc_alu u_alu (
        .mul_a   (mul_a),
        .mul_b   (mul_b),
        .product (product),
        .sub_a   (sub_a),
        .sub_b   (sub_b),
        .diff    (diff),
        .ge      (ge)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_rd[i] = aram_rdata[i*ACC_W +: ACC_W];
            v_rd[i]   = vram_rdata[i*POS_BITS +: POS_BITS];
        end
    end

    assign touched_rd = aram_rdata[3*ACC_W];
    assign zero_sum   = (acc_rd[0] == '0) && (acc_rd[1] == '0) && (acc_rd[2] == '0);
    assign any_big    = (|mag_reg[0][ACC_W-1:vnacc_pkg::SHIFT_LIMIT])
                     || (|mag_reg[1][ACC_W-1:vnacc_pkg::SHIFT_LIMIT])
                     || (|mag_reg[2][ACC_W-1:vnacc_pkg::SHIFT_LIMIT]);

    assign full    = (count_reg == CW'(MAX_VERTICES));
    assign few     = (count_reg < CW'(vnacc_pkg::MIN_TRI));
    assign bad_tri = (CMPW'(corner_reg[0]) >= CMPW'(count_reg))
                  || (CMPW'(corner_reg[1]) >= CMPW'(count_reg))
                  || (CMPW'(corner_reg[2]) >= CMPW'(count_reg));
    assign bad_q   = (CMPW'(query_reg) >= CMPW'(count_reg));

    assign resp_load = (state_reg == vnacc_pkg::S_RESP) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (comp_reg)
            2'd0:    sel_mag = mag_reg[0];
            2'd1:    sel_mag = mag_reg[1];
            default: sel_mag = mag_reg[2];
        endcase
    end

    assign quo_next = quo_reg | (ge ? (vnacc_pkg::DIV_Q_BITS'(1) << step_reg) : '0);
    assign q16      = vnacc_pkg::OUT_W'(quo_next);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vnacc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = vnacc_pkg::S_DECODE;
                end
            end
            vnacc_pkg::S_DECODE:
            begin
                case (kind_reg)
                    vnacc_pkg::KIND_TRI:
                        state_next = (few || bad_tri) ? vnacc_pkg::S_RESP : vnacc_pkg::S_TR_B;
                    vnacc_pkg::KIND_READ:
                        state_next = bad_q ? vnacc_pkg::S_RESP : vnacc_pkg::S_RD_LOAD;
                    default:
                        state_next = vnacc_pkg::S_RESP;
                endcase
            end
            vnacc_pkg::S_TR_B: state_next = vnacc_pkg::S_TR_C;
            vnacc_pkg::S_TR_C: state_next = vnacc_pkg::S_TR_E;
            vnacc_pkg::S_TR_E: state_next = vnacc_pkg::S_MUL;
            vnacc_pkg::S_MUL:
            begin
                if (step_reg == SW'(vnacc_pkg::CROSS_TERMS))
                begin
                    state_next = vnacc_pkg::S_ACC_RD;
                end
            end
            vnacc_pkg::S_ACC_RD: state_next = vnacc_pkg::S_ACC_WR;
            vnacc_pkg::S_ACC_WR:
            begin
                state_next = (comp_reg == 2'(vnacc_pkg::LAST_COMP)) ? vnacc_pkg::S_RESP
                                                                   : vnacc_pkg::S_ACC_RD;
            end
            vnacc_pkg::S_RD_LOAD:
            begin
                state_next = (!touched_rd || zero_sum) ? vnacc_pkg::S_RESP : vnacc_pkg::S_SHIFT;
            end
            vnacc_pkg::S_SHIFT:
            begin
                if (!any_big)
                begin
                    state_next = vnacc_pkg::S_SQUARE;
                end
            end
            vnacc_pkg::S_SQUARE:
            begin
                if (step_reg == SW'(vnacc_pkg::SQ_TERMS))
                begin
                    state_next = vnacc_pkg::S_SQRT;
                end
            end
            vnacc_pkg::S_SQRT:
            begin
                if (step_reg == SW'(vnacc_pkg::SQRT_STEPS - 1))
                begin
                    state_next = vnacc_pkg::S_DIV_INIT;
                end
            end
            vnacc_pkg::S_DIV_INIT: state_next = vnacc_pkg::S_DIV;
            vnacc_pkg::S_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = (comp_reg == 2'(vnacc_pkg::LAST_COMP)) ? vnacc_pkg::S_RESP
                                                                       : vnacc_pkg::S_DIV_INIT;
                end
            end
            vnacc_pkg::S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = vnacc_pkg::S_IDLE;
                end
            end
            default: state_next = vnacc_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready   = (state_reg == vnacc_pkg::S_IDLE);
        vram_we    = 1'b0;
        vram_waddr = AW'(count_reg);
        vram_raddr = AW'(corner_reg[0]);
        aram_we    = 1'b0;
        aram_waddr = AW'(count_reg);
        aram_wdata = '0;
        aram_raddr = AW'(query_reg);
        mul_a      = '0;
        mul_b      = '0;
        sub_a      = '0;
        sub_b      = '0;
        case (state_reg)
            vnacc_pkg::S_DECODE:
            begin
                if (kind_reg == vnacc_pkg::KIND_LOAD && !full)
                begin
                    vram_we = 1'b1;
                    aram_we = 1'b1;
                end
            end
            vnacc_pkg::S_TR_B: vram_raddr = AW'(corner_reg[1]);
            vnacc_pkg::S_TR_C: vram_raddr = AW'(corner_reg[2]);
            vnacc_pkg::S_MUL:
            begin
                case (step_reg)
                    SW'(0):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[1]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[2]);
                    end
                    SW'(1):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[2]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[1]);
                    end
                    SW'(2):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[2]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[0]);
                    end
                    SW'(3):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[0]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[2]);
                    end
                    SW'(4):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[0]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[1]);
                    end
                    SW'(5):
                    begin
                        mul_a = vnacc_pkg::MUL_W'(e1_reg[1]);
                        mul_b = vnacc_pkg::MUL_W'(e2_reg[0]);
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
            end
            vnacc_pkg::S_ACC_RD:
            begin
                aram_raddr = AW'(corner_reg[comp_reg]);
            end
            vnacc_pkg::S_ACC_WR:
            begin
                aram_we    = 1'b1;
                aram_waddr = AW'(corner_reg[comp_reg]);
                aram_wdata = {1'b1,
                              sat_add(acc_rd[2], cross_reg[2]),
                              sat_add(acc_rd[1], cross_reg[1]),
                              sat_add(acc_rd[0], cross_reg[0])};
            end
            vnacc_pkg::S_SQUARE:
            begin
                case (step_reg)
                    SW'(0):  mul_a = $signed({1'b0, mag_reg[0][vnacc_pkg::MUL_W-2:0]});
                    SW'(1):  mul_a = $signed({1'b0, mag_reg[1][vnacc_pkg::MUL_W-2:0]});
                    SW'(2):  mul_a = $signed({1'b0, mag_reg[2][vnacc_pkg::MUL_W-2:0]});
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            vnacc_pkg::S_SQRT:
            begin
                sub_a = sq_reg;
                sub_b = root_reg + bit_reg;
            end
            vnacc_pkg::S_DIV:
            begin
                sub_a = vnacc_pkg::SUB_W'(num_reg);
                sub_b = vnacc_pkg::SUB_W'(len_reg) << step_reg;
            end
            default:
            begin
                in_ready = (state_reg == vnacc_pkg::S_IDLE);
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vnacc_pkg::S_IDLE;
            count_reg     <= '0;
            dims_reg      <= 2'd3;
            step_reg      <= '0;
            comp_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            if (state_reg == vnacc_pkg::S_DECODE)
            begin
                if (kind_reg == vnacc_pkg::KIND_LOAD && !full)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else if (kind_reg == vnacc_pkg::KIND_CLEAR)
                begin
                    count_reg <= '0;
                end
            end
            case (state_reg)
                vnacc_pkg::S_TR_E:   step_reg <= '0;
                vnacc_pkg::S_MUL:    step_reg <= step_reg + SW'(1);
                vnacc_pkg::S_SHIFT:  step_reg <= '0;
                vnacc_pkg::S_SQUARE:
                    step_reg <= (step_reg == SW'(vnacc_pkg::SQ_TERMS)) ? '0 : step_reg + SW'(1);
                vnacc_pkg::S_SQRT:   step_reg <= step_reg + SW'(1);
                vnacc_pkg::S_DIV_INIT: step_reg <= SW'(vnacc_pkg::DIV_Q_BITS - 1);
                vnacc_pkg::S_DIV:    step_reg <= step_reg - SW'(1);
                default:             step_reg <= step_reg;
            endcase
            case (state_reg)
                vnacc_pkg::S_MUL:     comp_reg <= '0;
                vnacc_pkg::S_ACC_WR:  comp_reg <= comp_reg + 2'd1;
                vnacc_pkg::S_SQRT:    comp_reg <= '0;
                vnacc_pkg::S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                default:              comp_reg <= comp_reg;
            endcase
            if (resp_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg      <= vnacc_pkg::kind_t'(kind);
            vword_reg     <= {(dims_reg == vnacc_pkg::DIMS_2D) ? POS_BITS'(0) : pos_word(pos_z),
                              pos_word(pos_y), pos_word(pos_x)};
            corner_reg[0] <= corner_a;
            corner_reg[1] <= corner_b;
            corner_reg[2] <= corner_c;
            query_reg     <= query_index;
        end
        case (state_reg)
            vnacc_pkg::S_DECODE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= '0;
                end
                case (kind_reg)
                    vnacc_pkg::KIND_LOAD:
                    begin
                        stat_reg <= full ? vnacc_pkg::ST_FULL : vnacc_pkg::ST_OK;
                    end
                    vnacc_pkg::KIND_TRI:
                    begin
                        if (few)
                        begin
                            stat_reg <= vnacc_pkg::ST_FEW;
                        end
                        else if (bad_tri)
                        begin
                            stat_reg <= vnacc_pkg::ST_BAD_INDEX;
                        end
                        else
                        begin
                            stat_reg <= vnacc_pkg::ST_OK;
                        end
                    end
                    vnacc_pkg::KIND_READ:
                    begin
                        stat_reg <= bad_q ? vnacc_pkg::ST_BAD_INDEX : vnacc_pkg::ST_OK;
                    end
                    default:
                    begin
                        stat_reg <= vnacc_pkg::ST_OK;
                    end
                endcase
            end
            vnacc_pkg::S_TR_B:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p0_reg[i] <= v_rd[i];
                end
            end
            vnacc_pkg::S_TR_C:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p1_reg[i] <= v_rd[i];
                end
            end
            vnacc_pkg::S_TR_E:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= EW'(p1_reg[i]) - EW'(p0_reg[i]);
                    e2_reg[i] <= EW'(v_rd[i]) - EW'(p0_reg[i]);
                end
            end
            vnacc_pkg::S_MUL:
            begin
                prod_reg <= product;
                case (step_reg)
                    SW'(1):  cross_reg[0] <= CROSS_W'(prod_reg);
                    SW'(2):  cross_reg[0] <= cross_reg[0] - CROSS_W'(prod_reg);
                    SW'(3):  cross_reg[1] <= CROSS_W'(prod_reg);
                    SW'(4):  cross_reg[1] <= cross_reg[1] - CROSS_W'(prod_reg);
                    SW'(5):  cross_reg[2] <= CROSS_W'(prod_reg);
                    SW'(6):  cross_reg[2] <= cross_reg[2] - CROSS_W'(prod_reg);
                    default: cross_reg[0] <= cross_reg[0];
                endcase
            end
            vnacc_pkg::S_RD_LOAD:
            begin
                if (!touched_rd)
                begin
                    res_reg[1] <= vnacc_pkg::OUT_W'(vnacc_pkg::ONE_Q14);
                end
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= acc_rd[i][ACC_W-1];
                    mag_reg[i] <= acc_rd[i][ACC_W-1] ? ACC_W'(-acc_rd[i]) : acc_rd[i];
                end
            end
            vnacc_pkg::S_SHIFT:
            begin
                if (any_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                end
                sq_reg <= '0;
            end
            vnacc_pkg::S_SQUARE:
            begin
                prod_reg <= product;
                if (step_reg != '0)
                begin
                    sq_reg <= sq_reg + vnacc_pkg::SUB_W'(prod_reg);
                end
                root_reg <= '0;
                bit_reg  <= vnacc_pkg::SUB_W'(1) << (vnacc_pkg::SUB_W - 2);
            end
            vnacc_pkg::S_SQRT:
            begin
                if (ge)
                begin
                    sq_reg   <= diff;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (ge)
                begin
                    len_reg <= 32'((root_reg >> 1) + bit_reg);
                end
                else
                begin
                    len_reg <= 32'(root_reg >> 1);
                end
            end
            vnacc_pkg::S_DIV_INIT:
            begin
                num_reg <= vnacc_pkg::NUM_W'({sel_mag[vnacc_pkg::SHIFT_LIMIT-1:0],
                                              {vnacc_pkg::Q_FRAC{1'b0}}})
                         + vnacc_pkg::NUM_W'(len_reg >> 1);
                quo_reg <= '0;
            end
            vnacc_pkg::S_DIV:
            begin
                if (ge)
                begin
                    num_reg <= diff[vnacc_pkg::NUM_W-1:0];
                end
                quo_reg <= quo_next;
                if (step_reg == '0)
                begin
                    res_reg[comp_reg] <= neg_reg[comp_reg] ? -q16 : q16;
                end
            end
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        if (resp_load)
        begin
            nx_reg     <= res_reg[0];
            ny_reg     <= res_reg[1];
            nz_reg     <= res_reg[2];
            status_reg <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign normal_x  = nx_reg;
    assign normal_y  = ny_reg;
    assign normal_z  = nz_reg;
    assign status    = status_reg;

`include "vertex_normal_accumulator_unit_assert.svh"

    `VNACC_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && in_ready, !in_ready,
        "input ready while an item is in work")
    `VNACC_ASSERT_SAME(a_acc_write_loaded, clk, rst_n,
        aram_we && state_reg == vnacc_pkg::S_ACC_WR, CMPW'(aram_waddr) < CMPW'(count_reg),
        "accumulator update outside loaded vertices")
    `VNACC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(MAX_VERTICES),
        "vertex count beyond store depth")
    `VNACC_ASSERT_NEXT(a_resp_hold, clk, rst_n,
        state_reg == vnacc_pkg::S_RESP && out_valid_reg && !out_ready,
        state_reg == vnacc_pkg::S_RESP, "result dropped while output stalled")

endmodule
